// ===== hw/rtl/spherical_grid_hole_fill_top_assert.svh =====
// Assertion macros for the grid hole-fill block.
// Used by the port checker; depends on nothing else.
`ifndef SPHERICAL_GRID_HOLE_FILL_TOP_ASSERT_SVH
`define SPHERICAL_GRID_HOLE_FILL_TOP_ASSERT_SVH

// ante implies cons in the same cycle, off during reset
`define SHGF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle, live during reset
`define SHGF_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/shgf_pkg.sv =====
// Shared types, constants and the reciprocal table of the grid hole-fill block.
// Used by the top level and the average divider.
package shgf_pkg;

  localparam int DIST_W    = 16;
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 19;
  localparam int LAYER_W   = 5;
  localparam int SECTOR_W  = 5;
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;

  localparam logic [CFG_IDX_W-1:0] REG_LAYERS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESET   = 6'd32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic              known;
    logic [DIST_W-1:0] distance;
  } cell_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] quotient;
  } div_rsp_t;

  // floor(2^RECIP_SHIFT / c) for c = 1..8
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RECIP_W-1:0] r;
    case (c)
      4'd1:    r = 21'd1048576;
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349525;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209715;
      4'd6:    r = 21'd174762;
      4'd7:    r = 21'd149796;
      4'd8:    r = 21'd131072;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/spherical_grid_hole_fill_top.sv =====
// Top level of the grid hole-fill block: config registers, request sequencer,
// cell memory (shgf_ram) and average divider (shgf_div); uses shgf_pkg.
//
//   channel   signals                                    transaction
//   config    cfg_we, cfg_index, cfg_data                cfg_we high
//   request   start, busy, req_type, layer_index,        start high, busy low
//             sector_index, cell_distance, cell_known
//   result    done, filled_distance, was_filled,         done high, one cycle
//             neighbor_count, bad_address
//
// Write or out-of-range request: no result for an in-range write; the
// bad-address result follows in the next cycle. Results cannot be stalled.
// Read of a known cell: one cell memory read. Read of an unknown cell: eight
// neighbor reads through the single memory port plus the three-stage divider,
// skipped when no neighbor is known. After reset the known flags are cleared
// over all MAX_LAYERS * MAX_SECTORS cells, one cell a cycle, with busy high.
module spherical_grid_hole_fill_top #(
  parameter int MAX_LAYERS  = 32,
  parameter int MAX_SECTORS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [shgf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shgf_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [shgf_pkg::LAYER_W-1:0]    layer_index,
  input  logic [shgf_pkg::SECTOR_W-1:0]   sector_index,
  input  logic [shgf_pkg::DIST_W-1:0]     cell_distance,
  input  logic                            cell_known,
  output logic                            done,
  output logic [shgf_pkg::DIST_W-1:0]     filled_distance,
  output logic                            was_filled,
  output logic [shgf_pkg::CNT_W-1:0]      neighbor_count,
  output logic                            bad_address
);

  localparam int DEPTH  = MAX_LAYERS * MAX_SECTORS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CELL_W = $bits(shgf_pkg::cell_t);
  localparam int IW     = shgf_pkg::IDX_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CENTER = 3'd2;
  localparam logic [2:0] S_NBR    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;

  localparam logic [2:0] LAST_POS = 3'd7;

  logic [2:0]                     state;
  logic [AW-1:0]                  clr_addr;
  logic [shgf_pkg::CFG_W-1:0]     layers_in_use, sectors_in_use;
  logic [IW-1:0]                  nl, ns;
  logic [IW-1:0]                  in_layer, in_sector;
  logic                           accept, in_range;
  logic [AW-1:0]                  acc_addr, center_addr, issue_addr;
  logic [IW-1:0]                  row_up, row_mid, row_dn, col_l, col_m, col_r;
  logic                           up_ok, dn_ok;
  logic [2:0]                     pos, issue_pos;
  logic [IW-1:0]                  issue_row, issue_col;
  logic                           issue_ok, arrive_ok, hit;
  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [CELL_W-1:0]              ram_wdata, ram_rdata;
  shgf_pkg::cell_t                rd;
  logic [shgf_pkg::SUM_W-1:0]     sum, sum_next;
  logic [shgf_pkg::CNT_W-1:0]     cnt, cnt_next;
  shgf_pkg::div_req_t             dreq;
  shgf_pkg::div_rsp_t             drsp;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                              input logic [IW-1:0] col);
    int unsigned a;
    a = int'(row) * MAX_SECTORS + int'(col);
    return AW'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      layers_in_use  <= shgf_pkg::CFG_RESET;
      sectors_in_use <= shgf_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        shgf_pkg::REG_LAYERS:  layers_in_use  <= cfg_data;
        shgf_pkg::REG_SECTORS: sectors_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    nl = ((shgf_pkg::CFG_W + 1)'(layers_in_use) > (shgf_pkg::CFG_W + 1)'(MAX_LAYERS))
         ? IW'(MAX_LAYERS) : IW'(layers_in_use);
    ns = ((shgf_pkg::CFG_W + 1)'(sectors_in_use) > (shgf_pkg::CFG_W + 1)'(MAX_SECTORS))
         ? IW'(MAX_SECTORS) : IW'(sectors_in_use);
    in_layer  = IW'(layer_index);
    in_sector = IW'(sector_index);
    in_range  = (in_layer < nl) && (in_sector < ns);
    accept    = start && !busy;
    acc_addr  = cell_addr(in_layer, in_sector);
  end

  assign busy = (state != S_IDLE);

  // neighbor positions: 0..2 layer above, 3..4 same layer, 5..7 layer below
  always_comb begin
    issue_pos = (state == S_NBR) ? pos + 3'd1 : 3'd0;
    if (issue_pos inside {[3'd0:3'd2]}) begin
      issue_row = row_up;
      issue_ok  = up_ok;
    end else if (issue_pos inside {[3'd3:3'd4]}) begin
      issue_row = row_mid;
      issue_ok  = 1'b1;
    end else begin
      issue_row = row_dn;
      issue_ok  = dn_ok;
    end
    if (issue_pos inside {3'd0, 3'd3, 3'd5}) begin
      issue_col = col_l;
    end else if (issue_pos inside {3'd1, 3'd6}) begin
      issue_col = col_m;
    end else begin
      issue_col = col_r;
    end
    issue_addr = issue_ok ? cell_addr(issue_row, issue_col) : center_addr;

    if (pos inside {[3'd0:3'd2]}) begin
      arrive_ok = up_ok;
    end else if (pos inside {[3'd5:3'd7]}) begin
      arrive_ok = dn_ok;
    end else begin
      arrive_ok = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = center_addr;
    ram_wdata = {cell_known, cell_distance};
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_addr = acc_addr;
        ram_we   = accept && in_range && (req_type == shgf_pkg::REQ_WRITE);
      end
      S_CENTER, S_NBR: begin
        ram_addr = issue_addr;
      end
      default: ;
    endcase
  end

  shgf_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd         = shgf_pkg::cell_t'(ram_rdata);
    hit        = arrive_ok && rd.known;
    sum_next   = sum + (hit ? shgf_pkg::SUM_W'(rd.distance) : '0);
    cnt_next   = cnt + shgf_pkg::CNT_W'(hit);
    dreq.start = (state == S_NBR) && (pos == LAST_POS) && (cnt_next != '0);
    dreq.sum   = sum_next;
    dreq.cnt   = cnt_next;
  end

  shgf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!in_range) begin
              done <= 1'b1;
            end else if (req_type == shgf_pkg::REQ_READ) begin
              state <= S_CENTER;
            end
          end
        end
        S_CENTER: begin
          if (rd.known) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_NBR;
          end
        end
        S_NBR: begin
          if (pos == LAST_POS) begin
            if (cnt_next == '0) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          center_addr     <= acc_addr;
          row_up          <= in_layer - IW'(1);
          row_mid         <= in_layer;
          row_dn          <= in_layer + IW'(1);
          col_m           <= in_sector;
          col_l           <= (in_sector == '0) ? ns - IW'(1) : in_sector - IW'(1);
          col_r           <= (in_sector + IW'(1) == ns) ? '0 : in_sector + IW'(1);
          up_ok           <= (in_layer != '0);
          dn_ok           <= (in_layer + IW'(1)) < nl;
          filled_distance <= '0;
          was_filled      <= 1'b0;
          neighbor_count  <= '0;
          bad_address     <= !in_range;
        end
      end
      S_CENTER: begin
        pos             <= '0;
        sum             <= '0;
        cnt             <= '0;
        filled_distance <= rd.distance;
        was_filled      <= 1'b0;
        neighbor_count  <= '0;
        bad_address     <= 1'b0;
      end
      S_NBR: begin
        sum <= sum_next;
        cnt <= cnt_next;
        pos <= pos + 3'd1;
        if (pos == LAST_POS) begin
          filled_distance <= '0;
          was_filled      <= 1'b1;
          neighbor_count  <= '0;
        end
      end
      S_DIV: begin
        filled_distance <= drsp.quotient;
        was_filled      <= 1'b1;
        neighbor_count  <= cnt;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/shgf_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Stand-alone; no package needed.
module shgf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/shgf_div.sv =====
// Three-stage divider of a neighbor sum by a count of one to eight.
// Reciprocal multiply, then one correction step; uses shgf_pkg.
module shgf_div (
  input  logic               clk,
  input  logic               rst,
  input  shgf_pkg::div_req_t req,
  output shgf_pkg::div_rsp_t rsp
);

  localparam int PW = shgf_pkg::SUM_W + shgf_pkg::RECIP_W;
  localparam int RW = shgf_pkg::SUM_W + shgf_pkg::CNT_W;

  logic                        v1, v2;
  logic [PW-1:0]               prod1;
  logic [shgf_pkg::SUM_W-1:0]  sum1, sum2, q2;
  logic [shgf_pkg::CNT_W-1:0]  cnt1, cnt2;
  logic [RW-1:0]               back, rem;
  logic                        bump;
  logic                        done_r;
  logic [shgf_pkg::DIST_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1     <= req.start;
      v2     <= v1;
      done_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    prod1 <= PW'(req.sum) * PW'(shgf_pkg::recip(req.cnt));
    sum1  <= req.sum;
    cnt1  <= req.cnt;
    q2    <= prod1[shgf_pkg::RECIP_SHIFT +: shgf_pkg::SUM_W];
    sum2  <= sum1;
    cnt2  <= cnt1;
    quot  <= shgf_pkg::DIST_W'(q2 + shgf_pkg::SUM_W'(bump));
  end

  always_comb begin
    back = RW'(q2) * RW'(cnt2);
    rem  = RW'(sum2) - back;
    bump = rem >= RW'(cnt2);
  end

  assign rsp = {done_r, quot};

endmodule

// ===== hw/rtl/shgf_checker.sv =====
// Port-level checker of the grid hole-fill block, bound to the top level.
// Depends on shgf_pkg and spherical_grid_hole_fill_top_assert.svh.
`include "spherical_grid_hole_fill_top_assert.svh"

module shgf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        done,
  input logic [shgf_pkg::DIST_W-1:0] filled_distance,
  input logic                        was_filled,
  input logic [shgf_pkg::CNT_W-1:0]  neighbor_count,
  input logic                        bad_address
);

  `SHGF_ASSERT_IMPL(a_bad_clean, clk, rst, done && bad_address, filled_distance == '0 && neighbor_count == '0 && !was_filled, "bad-address result carries data")
  `SHGF_ASSERT_IMPL(a_count_range, clk, rst, done, neighbor_count <= 4'd8, "neighbor count above eight")
  `SHGF_ASSERT_IMPL(a_known_zero, clk, rst, done && !was_filled, neighbor_count == '0, "known cell reports neighbors")
  `SHGF_ASSERT_NEXT(a_reset_clear, clk, rst, busy && !done, "no clearing pass after reset")

endmodule

bind spherical_grid_hole_fill_top shgf_checker u_shgf_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for spherical_grid_hole_fill_top: a scoreboard class predicts every
// read, fill and bad-address result; tasks drive requests and config writes.
// Depends on shgf_pkg and the RTL of the block only.
module tb_top;

  localparam int GRID_LAYERS   = 32;
  localparam int GRID_SECTORS  = 32;
  localparam int GRID_CELLS    = GRID_LAYERS * GRID_SECTORS;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 5000;

  typedef struct packed {
    logic                          op;
    logic [shgf_pkg::LAYER_W-1:0]  layer;
    logic [shgf_pkg::SECTOR_W-1:0] sector;
    logic [shgf_pkg::DIST_W-1:0]   distance;
    logic                          known;
  } grid_req_t;

  typedef struct packed {
    logic [shgf_pkg::DIST_W-1:0] distance;
    logic                        filled;
    logic [shgf_pkg::CNT_W-1:0]  count;
    logic                        bad;
  } fill_t;

  class grid_fill_scoreboard;
    bit [shgf_pkg::DIST_W-1:0] dist_cells[GRID_CELLS];
    bit                        known_cells[GRID_CELLS];
    bit [shgf_pkg::CFG_W-1:0]  layers_reg;
    bit [shgf_pkg::CFG_W-1:0]  sectors_reg;
    fill_t                     expected_fills[$];
    int                        mismatches;

    function new();
      foreach (known_cells[i]) begin
        known_cells[i] = 1'b0;
        dist_cells[i]  = '0;
      end
      layers_reg  = shgf_pkg::CFG_RESET;
      sectors_reg = shgf_pkg::CFG_RESET;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [shgf_pkg::CFG_IDX_W-1:0] index,
                            logic [shgf_pkg::CFG_W-1:0] value);
      if (index == shgf_pkg::REG_LAYERS) begin
        layers_reg = value;
      end else if (index == shgf_pkg::REG_SECTORS) begin
        sectors_reg = value;
      end
    endfunction

    function void take_request(grid_req_t q);
      int unsigned nl, ns, addr, left, right, total, hits, row, first, last, k, col;
      fill_t r;
      nl = (layers_reg > GRID_LAYERS) ? GRID_LAYERS : layers_reg;
      ns = (sectors_reg > GRID_SECTORS) ? GRID_SECTORS : sectors_reg;
      r.distance = '0;
      r.filled   = 1'b0;
      r.count    = '0;
      r.bad      = 1'b0;
      if (q.layer >= nl || q.sector >= ns) begin
        r.bad = 1'b1;
        expected_fills.push_back(r);
        return;
      end
      addr = q.layer * GRID_SECTORS + q.sector;
      if (q.op == shgf_pkg::REQ_WRITE) begin
        dist_cells[addr]  = q.distance;
        known_cells[addr] = q.known;
        return;
      end
      if (known_cells[addr]) begin
        r.distance = dist_cells[addr];
        expected_fills.push_back(r);
        return;
      end
      left  = (q.sector == 0) ? ns - 1 : q.sector - 1;
      right = (q.sector + 1 == ns) ? 0 : q.sector + 1;
      first = (q.layer > 0) ? q.layer - 1 : q.layer;
      last  = (q.layer + 1 < nl) ? q.layer + 1 : q.layer;
      total = 0;
      hits  = 0;
      for (row = first; row <= last; row++) begin
        for (k = 0; k < 3; k++) begin
          col = (k == 0) ? left : ((k == 1) ? q.sector : right);
          if (!(row == q.layer && k == 1) && known_cells[row * GRID_SECTORS + col]) begin
            total += dist_cells[row * GRID_SECTORS + col];
            hits++;
          end
        end
      end
      r.distance = (hits != 0) ? shgf_pkg::DIST_W'(total / hits) : '0;
      r.filled   = 1'b1;
      r.count    = shgf_pkg::CNT_W'(hits);
      expected_fills.push_back(r);
    endfunction

    function void check_fill(fill_t got);
      fill_t want;
      if (expected_fills.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result dist=%h filled=%b count=%0d bad=%b",
                 $time, got.distance, got.filled, got.count, got.bad);
        return;
      end
      want = expected_fills.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: mismatch expected dist=%h filled=%b count=%0d bad=%b",
                 $time, want.distance, want.filled, want.count, want.bad);
        $display("%0t:          actual   dist=%h filled=%b count=%0d bad=%b",
                 $time, got.distance, got.filled, got.count, got.bad);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [shgf_pkg::CFG_IDX_W-1:0] cfg_index = shgf_pkg::REG_LAYERS;
  logic [shgf_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           req_type = shgf_pkg::REQ_WRITE;
  logic [shgf_pkg::LAYER_W-1:0]   layer_index = '0;
  logic [shgf_pkg::SECTOR_W-1:0]  sector_index = '0;
  logic [shgf_pkg::DIST_W-1:0]    cell_distance = '0;
  logic                           cell_known = 1'b0;
  logic                           done;
  logic [shgf_pkg::DIST_W-1:0]    filled_distance;
  logic                           was_filled;
  logic [shgf_pkg::CNT_W-1:0]     neighbor_count;
  logic                           bad_address;

  grid_fill_scoreboard sb = new();
  int idle_cycles = 0;
  bit burst_mode = 1'b0;

  spherical_grid_hole_fill_top #(
    .MAX_LAYERS (GRID_LAYERS),
    .MAX_SECTORS(GRID_SECTORS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .layer_index    (layer_index),
    .sector_index   (sector_index),
    .cell_distance  (cell_distance),
    .cell_known     (cell_known),
    .done           (done),
    .filled_distance(filled_distance),
    .was_filled     (was_filled),
    .neighbor_count (neighbor_count),
    .bad_address    (bad_address)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    fill_t     got;
    grid_req_t q;
    if (!rst) begin
      if (done !== 1'b0) begin
        got.distance = filled_distance;
        got.filled   = was_filled;
        got.count    = neighbor_count;
        got.bad      = bad_address;
        sb.check_fill(got);
      end
      if (start && busy === 1'b0) begin
        q.op       = req_type;
        q.layer    = layer_index;
        q.sector   = sector_index;
        q.distance = cell_distance;
        q.known    = cell_known;
        sb.take_request(q);
      end
      if (cfg_we) begin
        sb.write_reg(cfg_index, cfg_data);
      end
    end
    if (done === 1'b1 || (start && busy === 1'b0) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("** spherical_grid_hole_fill_top: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int in_use(int value, int limit);
    return (value > limit) ? limit : value;
  endfunction

  function automatic grid_req_t random_request(int nl, int ns);
    grid_req_t q;
    q.op    = ($urandom_range(0, 99) < 45) ? shgf_pkg::REQ_READ : shgf_pkg::REQ_WRITE;
    q.known = ($urandom_range(0, 99) < 75);
    if (nl == 0 || ns == 0 || $urandom_range(0, 99) < 8) begin
      q.layer  = shgf_pkg::LAYER_W'($urandom_range(0, 31));
      q.sector = shgf_pkg::SECTOR_W'($urandom_range(0, 31));
    end else begin
      q.layer  = shgf_pkg::LAYER_W'($urandom_range(0, nl - 1));
      q.sector = shgf_pkg::SECTOR_W'($urandom_range(0, ns - 1));
    end
    case ($urandom_range(0, 5))
      0:       q.distance = '0;
      1:       q.distance = '1;
      2:       q.distance = shgf_pkg::DIST_W'($urandom_range(16'hFF00, 16'hFFFF));
      default: q.distance = shgf_pkg::DIST_W'($urandom);
    endcase
    return q;
  endfunction

  task automatic send_request(input grid_req_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    req_type      <= q.op;
    layer_index   <= q.layer;
    sector_index  <= q.sector;
    cell_distance <= q.distance;
    cell_known    <= q.known;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic issue(input logic op, input int layer, input int sector,
                       input logic [shgf_pkg::DIST_W-1:0] distance, input logic known);
    grid_req_t q;
    q.op       = op;
    q.layer    = shgf_pkg::LAYER_W'(layer);
    q.sector   = shgf_pkg::SECTOR_W'(sector);
    q.distance = distance;
    q.known    = known;
    send_request(q);
  endtask

  // hold requests until every result is in and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_fills.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input int layers, input int sectors);
    cfg_we    <= 1'b1;
    cfg_index <= shgf_pkg::REG_LAYERS;
    cfg_data  <= shgf_pkg::CFG_W'(layers);
    @(posedge clk);
    cfg_index <= shgf_pkg::REG_SECTORS;
    cfg_data  <= shgf_pkg::CFG_W'(sectors);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int layers, input int sectors, input int items,
                           input bit no_gaps);
    drain();
    set_grid(layers, sectors);
    burst_mode = no_gaps;
    repeat (items) begin
      send_request(random_request(in_use(layers, GRID_LAYERS),
                                  in_use(sectors, GRID_SECTORS)));
    end
    burst_mode = 1'b0;
  endtask

  initial begin : stimulus
    int p;
    int phase_layers[11]  = '{32, 4, 1, 2, 1, 32, 3, 0, 8, 63, 33};
    int phase_sectors[11] = '{32, 4, 1, 2, 32, 1, 2, 8, 0, 63, 5};
    int phase_items[11]   = '{200, 150, 60, 120, 100, 100, 150, 30, 30, 150, 120};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain();

    // reset grid: empty fill, wrap, clip, full-scale average, unknown write
    issue(shgf_pkg::REQ_READ, 0, 0, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_WRITE, 0, 31, 16'hFFFF, 1'b1);
    issue(shgf_pkg::REQ_WRITE, 1, 0, 16'hFFFF, 1'b1);
    issue(shgf_pkg::REQ_WRITE, 1, 1, 16'hFFFF, 1'b1);
    issue(shgf_pkg::REQ_WRITE, 0, 1, 16'hFFFF, 1'b1);
    issue(shgf_pkg::REQ_READ, 0, 0, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_WRITE, 1, 31, 16'h0001, 1'b1);
    issue(shgf_pkg::REQ_READ, 0, 0, 16'hFFFF, 1'b1);
    issue(shgf_pkg::REQ_WRITE, 0, 0, 16'h1234, 1'b0);
    issue(shgf_pkg::REQ_READ, 0, 0, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_WRITE, 0, 0, 16'h1234, 1'b1);
    issue(shgf_pkg::REQ_READ, 0, 0, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_READ, 31, 31, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_WRITE, 30, 31, 16'h0000, 1'b1);
    issue(shgf_pkg::REQ_READ, 31, 31, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_READ, 31, 0, 16'h0000, 1'b0);

    // two sectors: doubled side neighbors, out-of-range write and read
    drain();
    set_grid(3, 2);
    issue(shgf_pkg::REQ_WRITE, 5, 0, 16'hABCD, 1'b1);
    issue(shgf_pkg::REQ_READ, 0, 2, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_READ, 2, 1, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_READ, 1, 0, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_WRITE, 1, 0, 16'h5555, 1'b0);
    issue(shgf_pkg::REQ_READ, 1, 0, 16'h0000, 1'b0);

    // zero registers: every address out of range
    drain();
    set_grid(0, 0);
    issue(shgf_pkg::REQ_READ, 0, 0, 16'h0000, 1'b0);
    issue(shgf_pkg::REQ_WRITE, 31, 31, 16'hFFFF, 1'b1);

    for (p = 0; p < 11; p++) begin
      run_phase(phase_layers[p], phase_sectors[p], phase_items[p], (p % 3) == 2);
    end
    repeat (3) begin
      run_phase($urandom_range(1, 32), $urandom_range(1, 32), 100, 1'b0);
    end
    drain();

    if (sb.mismatches == 0) begin
      $display("** spherical_grid_hole_fill_top: PASSED **");
    end else begin
      $display("** spherical_grid_hole_fill_top: FAILED **");
    end
    $finish;
  end
endmodule
